@@ hdl/hng_pkg.sv @@
// shared widths, status codes and table entry types for the hamming number generator
`default_nettype none

package hng_pkg;

  localparam int IDX_W    = 13;
  localparam int STATUS_W = 2;
  localparam int EXP2_W   = 6;
  localparam int EXP3_W   = 6;
  localparam int EXP5_W   = 5;
  localparam int VAL_W    = 64;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [EXP2_W-1:0] two;
    logic [EXP3_W-1:0] three;
    logic [EXP5_W-1:0] five;
  } exp_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    exp_t             exps;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // contents of entry 0 after reset: the number one, all exponents zero
  localparam entry_t ENTRY_ONE = '{value: 64'd1, exps: '0};

endpackage

`default_nettype wire

@@ hdl/hng_if.sv @@
// valid/ready channel interfaces for index requests and generated results
`default_nettype none

interface hng_in_if;
  logic                      valid;
  logic                      ready;
  logic [hng_pkg::IDX_W-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

interface hng_out_if;
  logic                         valid;
  logic                         ready;
  logic [hng_pkg::STATUS_W-1:0] status;
  logic [hng_pkg::EXP2_W-1:0]   exp_two;
  logic [hng_pkg::EXP3_W-1:0]   exp_three;
  logic [hng_pkg::EXP5_W-1:0]   exp_five;
  logic [hng_pkg::VAL_W-1:0]    number_value;

  modport source (output valid, output status, output exp_two, output exp_three,
                  output exp_five, output number_value, input ready);
  modport sink   (input valid, input status, input exp_two, input exp_three,
                  input exp_five, input number_value, output ready);
endinterface

`default_nettype wire

@@ hdl/hamming_number_generator_unit.sv @@
// hamming number generator: three-pointer merge over a table of generated entries
//
// Usage: the in_ch channel takes a one-based index n; the out_ch channel returns one
// result per index: a status, the exponents of 2, 3 and 5 and the 64-bit value of the
// nth 5-smooth number. Both channels move a transfer when valid and ready are high.
// Index zero or an index above TABLE_DEPTH returns an error status with zero fields.
// An index already in the table passes the lookup and response states before it loads
// the output register, an error passes response alone; each missing entry adds states
// RD_TWO, RD_THR, RD_FIV, LAST and WRITE: the sequencer reads the three pointed entries
// one after another through the single ram read port, and one shared adder/comparator
// forms 2x, 3x and 5x and keeps the running minimum. Entries once made stay cached.
// The block takes one index at a time; in_ch.ready is high only while the sequencer
// is idle, which includes the time a finished result waits in the output register.
// When the receiver stalls, the result holds in the output register and the next
// index may still be taken and worked on until its own result is ready to load.
// Reset (rst_n, synchronous, active low) clears the sequencer and pointers, sets the
// entry count to one; entry 0 reads as one without any ram write, so no clearing pass.
`default_nettype none

module hamming_number_generator_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hng_in_if.sink     in_ch,
  hng_out_if.source  out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_TWO = 3'd1;
  localparam logic [2:0] S_RD_THR = 3'd2;
  localparam logic [2:0] S_RD_FIV = 3'd3;
  localparam logic [2:0] S_LAST   = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_LOOKUP = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [hng_pkg::IDX_W-1:0]    index_r, index_nxt;
  logic [hng_pkg::STATUS_W-1:0] err_r, err_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                ptr_two_r, ptr_two_nxt;
  logic [AW-1:0]                ptr_three_r, ptr_three_nxt;
  logic [AW-1:0]                ptr_five_r, ptr_five_nxt;
  logic [hng_pkg::VAL_W-1:0]    min_r, min_nxt;
  hng_pkg::exp_t                exp_r, exp_nxt;
  logic [2:0]                   sel_r, sel_nxt;
  logic                         zero_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [hng_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  hng_pkg::entry_t              out_entry_r, out_entry_nxt;

  logic [AW-1:0]                raddr;
  logic [hng_pkg::IDX_W-1:0]    index_dec;
  logic [hng_pkg::ENTRY_W-1:0]  ram_q;
  hng_pkg::entry_t              rd_entry;
  hng_pkg::entry_t              wr_entry;
  logic                         wr_en;
  logic [1:0]                   shamt;
  logic [hng_pkg::VAL_W-1:0]    cand;
  logic                         cand_lt;
  logic                         cand_eq;
  logic                         out_free;

  assign index_dec = index_r - 1'b1;
  assign out_free  = !out_valid_r || out_ch.ready;

  // ram read address: pointed entry while generating, otherwise the requested slot
  always_comb begin
    unique case (state_r)
      S_RD_TWO: raddr = ptr_two_r;
      S_RD_THR: raddr = ptr_three_r;
      S_RD_FIV: raddr = ptr_five_r;
      default:  raddr = index_dec[AW-1:0];
    endcase
  end

  assign wr_en    = (state_r == S_WRITE);
  assign wr_entry = '{value: min_r, exps: exp_r};

  hng_ram #(
    .WIDTH (hng_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // entry 0 is fixed at one and never written
  always_ff @(posedge clk) begin
    zero_r <= (raddr == '0);
  end

  assign rd_entry = zero_r ? hng_pkg::ENTRY_ONE : hng_pkg::entry_t'(ram_q);

  // shared unit: x + (x << k) gives 2x, 3x, 5x; compared against the running minimum
  always_comb begin
    unique case (state_r)
      S_RD_THR: shamt = 2'd0;
      S_RD_FIV: shamt = 2'd1;
      default:  shamt = 2'd2;
    endcase
  end

  assign cand    = rd_entry.value + (rd_entry.value << shamt);
  assign cand_lt = cand < min_r;
  assign cand_eq = cand == min_r;

  // sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    index_nxt      = index_r;
    err_nxt        = err_r;
    count_nxt      = count_r;
    ptr_two_nxt    = ptr_two_r;
    ptr_three_nxt  = ptr_three_r;
    ptr_five_nxt   = ptr_five_r;
    min_nxt        = min_r;
    exp_nxt        = exp_r;
    sel_nxt        = sel_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          index_nxt = in_ch.index;
          priority if (in_ch.index == '0) begin
            err_nxt   = hng_pkg::ST_ZERO;
            state_nxt = S_RESP;
          end else if (32'(in_ch.index) > 32'(TABLE_DEPTH)) begin
            err_nxt   = hng_pkg::ST_RANGE;
            state_nxt = S_RESP;
          end else if (32'(in_ch.index) <= 32'(count_r)) begin
            err_nxt   = hng_pkg::ST_OK;
            state_nxt = S_LOOKUP;
          end else begin
            err_nxt   = hng_pkg::ST_OK;
            state_nxt = S_RD_TWO;
          end
        end
      end
      S_RD_TWO: begin
        state_nxt = S_RD_THR;
      end
      // 2x always seeds the minimum
      S_RD_THR: begin
        min_nxt       = cand;
        exp_nxt       = rd_entry.exps;
        exp_nxt.two   = rd_entry.exps.two + 1'b1;
        sel_nxt       = 3'b001;
        state_nxt     = S_RD_FIV;
      end
      // 3x against the minimum; a tie keeps the earlier exponents
      S_RD_FIV: begin
        if (cand_lt) begin
          min_nxt       = cand;
          exp_nxt       = rd_entry.exps;
          exp_nxt.three = rd_entry.exps.three + 1'b1;
          sel_nxt       = 3'b010;
        end else if (cand_eq) begin
          sel_nxt = sel_r | 3'b010;
        end
        state_nxt = S_LAST;
      end
      // 5x against the minimum
      S_LAST: begin
        if (cand_lt) begin
          min_nxt      = cand;
          exp_nxt      = rd_entry.exps;
          exp_nxt.five = rd_entry.exps.five + 1'b1;
          sel_nxt      = 3'b100;
        end else if (cand_eq) begin
          sel_nxt = sel_r | 3'b100;
        end
        state_nxt = S_WRITE;
      end
      // store the new entry and advance every pointer that produced it
      S_WRITE: begin
        count_nxt     = count_r + 1'b1;
        ptr_two_nxt   = ptr_two_r + AW'(sel_r[0]);
        ptr_three_nxt = ptr_three_r + AW'(sel_r[1]);
        ptr_five_nxt  = ptr_five_r + AW'(sel_r[2]);
        if (32'(count_r) + 32'd1 >= 32'(index_r)) begin
          state_nxt = S_LOOKUP;
        end else begin
          state_nxt = S_RD_TWO;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_RESP;
      end
      // load the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_r;
          if (err_r == hng_pkg::ST_OK) begin
            out_entry_nxt = rd_entry;
          end else begin
            out_entry_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      ptr_two_r   <= '0;
      ptr_three_r <= '0;
      ptr_five_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_two_r   <= ptr_two_nxt;
      ptr_three_r <= ptr_three_nxt;
      ptr_five_r  <= ptr_five_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    index_r      <= index_nxt;
    err_r        <= err_nxt;
    min_r        <= min_nxt;
    exp_r        <= exp_nxt;
    sel_r        <= sel_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  // channel ports
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.exp_two      = out_entry_r.exps.two;
  assign out_ch.exp_three    = out_entry_r.exps.three;
  assign out_ch.exp_five     = out_entry_r.exps.five;
  assign out_ch.number_value = out_entry_r.value;

endmodule

`default_nettype wire

@@ hdl/hng_ram.sv @@
// generic single write port, single read port ram with registered read data
`default_nettype none

module hng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/hng_checker.sv @@
// port-level checker for the hamming number generator and its bind to the top level
`default_nettype none

module hng_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [hng_pkg::STATUS_W-1:0] status,
  input wire logic [hng_pkg::EXP2_W-1:0]   exp_two,
  input wire logic [hng_pkg::EXP3_W-1:0]   exp_three,
  input wire logic [hng_pkg::EXP5_W-1:0]   exp_five,
  input wire logic [hng_pkg::VAL_W-1:0]    number_value
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(number_value) && $stable(status))
    else $error("stalled result changed");

  // one index at a time: busy right after a transfer in
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while still busy");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == hng_pkg::ST_ZERO || status == hng_pkg::ST_RANGE) |->
      number_value == '0 && exp_two == '0 && exp_three == '0 && exp_five == '0)
    else $error("error result with nonzero fields");

  // a good result is never zero and its status is a known code
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == hng_pkg::ST_ZERO || status == hng_pkg::ST_RANGE ||
                   (status == hng_pkg::ST_OK && number_value != '0)))
    else $error("bad status or zero value");

endmodule

bind hamming_number_generator_unit hng_checker u_hng_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .exp_two      (out_ch.exp_two),
  .exp_three    (out_ch.exp_three),
  .exp_five     (out_ch.exp_five),
  .number_value (out_ch.number_value)
);

`default_nettype wire
